[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/rvdec_pkg.sv]
`default_nettype none

package rvdec_pkg;

   localparam logic [6:0] OP_LOAD     = 7'h03;
   localparam logic [6:0] OP_MISC_MEM = 7'h0F;
   localparam logic [6:0] OP_IMM      = 7'h13;
   localparam logic [6:0] OP_AUIPC    = 7'h17;
   localparam logic [6:0] OP_STORE    = 7'h23;
   localparam logic [6:0] OP_REG      = 7'h33;
   localparam logic [6:0] OP_LUI      = 7'h37;
   localparam logic [6:0] OP_BRANCH   = 7'h63;
   localparam logic [6:0] OP_JALR     = 7'h67;
   localparam logic [6:0] OP_JAL      = 7'h6F;
   localparam logic [6:0] OP_SYSTEM   = 7'h73;

   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   localparam logic [2:0] F3_ADD_SUB     = 3'd0;
   localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;
   localparam logic [2:0] F3_PRIV        = 3'd0;

   localparam logic [2:0] FMT_R       = 3'd0;
   localparam logic [2:0] FMT_I       = 3'd1;
   localparam logic [2:0] FMT_S       = 3'd2;
   localparam logic [2:0] FMT_B       = 3'd3;
   localparam logic [2:0] FMT_U       = 3'd4;
   localparam logic [2:0] FMT_J       = 3'd5;
   localparam logic [2:0] FMT_UNKNOWN = 3'd6;

   localparam logic [5:0] INSN_NONE    = 6'd0;
   localparam logic [5:0] INSN_LB      = 6'd1;
   localparam logic [5:0] INSN_LH      = 6'd2;
   localparam logic [5:0] INSN_LW      = 6'd3;
   localparam logic [5:0] INSN_LBU     = 6'd4;
   localparam logic [5:0] INSN_LHU     = 6'd5;
   localparam logic [5:0] INSN_FENCE   = 6'd6;
   localparam logic [5:0] INSN_FENCE_I = 6'd7;
   localparam logic [5:0] INSN_ADDI    = 6'd8;
   localparam logic [5:0] INSN_SLLI    = 6'd9;
   localparam logic [5:0] INSN_SLTI    = 6'd10;
   localparam logic [5:0] INSN_SLTIU   = 6'd11;
   localparam logic [5:0] INSN_XORI    = 6'd12;
   localparam logic [5:0] INSN_SRLI    = 6'd13;
   localparam logic [5:0] INSN_SRAI    = 6'd14;
   localparam logic [5:0] INSN_ORI     = 6'd15;
   localparam logic [5:0] INSN_ANDI    = 6'd16;
   localparam logic [5:0] INSN_AUIPC   = 6'd17;
   localparam logic [5:0] INSN_SB      = 6'd18;
   localparam logic [5:0] INSN_SH      = 6'd19;
   localparam logic [5:0] INSN_SW      = 6'd20;
   localparam logic [5:0] INSN_ADD     = 6'd21;
   localparam logic [5:0] INSN_SUB     = 6'd22;
   localparam logic [5:0] INSN_SLL     = 6'd23;
   localparam logic [5:0] INSN_SLT     = 6'd24;
   localparam logic [5:0] INSN_SLTU    = 6'd25;
   localparam logic [5:0] INSN_XOR     = 6'd26;
   localparam logic [5:0] INSN_SRL     = 6'd27;
   localparam logic [5:0] INSN_SRA     = 6'd28;
   localparam logic [5:0] INSN_OR      = 6'd29;
   localparam logic [5:0] INSN_AND     = 6'd30;
   localparam logic [5:0] INSN_LUI     = 6'd31;
   localparam logic [5:0] INSN_BEQ     = 6'd32;
   localparam logic [5:0] INSN_BNE     = 6'd33;
   localparam logic [5:0] INSN_BLT     = 6'd34;
   localparam logic [5:0] INSN_BGE     = 6'd35;
   localparam logic [5:0] INSN_BLTU    = 6'd36;
   localparam logic [5:0] INSN_BGEU    = 6'd37;
   localparam logic [5:0] INSN_JALR    = 6'd38;
   localparam logic [5:0] INSN_JAL     = 6'd39;
   localparam logic [5:0] INSN_ECALL   = 6'd40;
   localparam logic [5:0] INSN_EBREAK  = 6'd41;
   localparam logic [5:0] INSN_CSRRW   = 6'd42;
   localparam logic [5:0] INSN_CSRRS   = 6'd43;
   localparam logic [5:0] INSN_CSRRC   = 6'd44;
   localparam logic [5:0] INSN_CSRRWI  = 6'd45;
   localparam logic [5:0] INSN_CSRRSI  = 6'd46;
   localparam logic [5:0] INSN_CSRRCI  = 6'd47;

   // Instruction numbers by funct3 for each major opcode that funct3 divides.
   localparam logic [5:0] LOAD_NUM [8] = '{INSN_LB, INSN_LH, INSN_LW, INSN_NONE,
                                           INSN_LBU, INSN_LHU, INSN_NONE, INSN_NONE};
   localparam logic [5:0] MISC_NUM [8] = '{INSN_FENCE, INSN_FENCE_I, INSN_NONE, INSN_NONE,
                                           INSN_NONE, INSN_NONE, INSN_NONE, INSN_NONE};
   localparam logic [5:0] IMM_NUM [8] = '{INSN_ADDI, INSN_SLLI, INSN_SLTI, INSN_SLTIU,
                                          INSN_XORI, INSN_SRLI, INSN_ORI, INSN_ANDI};
   localparam logic [5:0] STORE_NUM [8] = '{INSN_SB, INSN_SH, INSN_SW, INSN_NONE,
                                            INSN_NONE, INSN_NONE, INSN_NONE, INSN_NONE};
   localparam logic [5:0] REG_NUM [8] = '{INSN_ADD, INSN_SLL, INSN_SLT, INSN_SLTU,
                                          INSN_XOR, INSN_SRL, INSN_OR, INSN_AND};
   localparam logic [5:0] BRANCH_NUM [8] = '{INSN_BEQ, INSN_BNE, INSN_NONE, INSN_NONE,
                                             INSN_BLT, INSN_BGE, INSN_BLTU, INSN_BGEU};
   localparam logic [5:0] SYS_NUM [8] = '{INSN_NONE, INSN_CSRRW, INSN_CSRRS, INSN_CSRRC,
                                          INSN_NONE, INSN_CSRRWI, INSN_CSRRSI, INSN_CSRRCI};

   typedef struct packed {
      logic [5:0]         number;
      logic [2:0]         fmt;
      logic [6:0]         opcode;
      logic [2:0]         funct3;
      logic [6:0]         funct7;
      logic [4:0]         rd;
      logic [4:0]         rs1;
      logic [4:0]         rs2;
      logic signed [31:0] imm;
      logic [11:0]        csr;
   } dec_result_type;

endpackage

`default_nettype wire

[rtl/core/rvdec_decode.sv]
`default_nettype none

module rvdec_decode
   import rvdec_pkg::*;
(
   input  wire logic [31:0]    word,
   output dec_result_type      result
);

   logic [6:0] op;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [5:0] num;
   logic [2:0] fmt;

   assign op = word[6:0];
   assign f3 = word[14:12];
   assign f7 = word[31:25];

   always_comb begin
      num = INSN_NONE;
      fmt = FMT_UNKNOWN;
      unique case (op)
         OP_LOAD: begin
            num = LOAD_NUM[f3];
            fmt = FMT_I;
         end
         OP_MISC_MEM: begin
            num = MISC_NUM[f3];
            fmt = FMT_I;
         end
         OP_IMM: begin
            num = IMM_NUM[f3];
            if (f3 == F3_SHIFT_RIGHT && f7 != '0) begin
               num = INSN_SRAI;
            end
            fmt = FMT_I;
         end
         OP_AUIPC: begin
            num = INSN_AUIPC;
            fmt = FMT_U;
         end
         OP_STORE: begin
            num = STORE_NUM[f3];
            fmt = FMT_S;
         end
         OP_REG: begin
            num = REG_NUM[f3];
            if (f3 == F3_ADD_SUB && f7 != '0) begin
               num = INSN_SUB;
            end else if (f3 == F3_SHIFT_RIGHT && f7 != '0) begin
               num = INSN_SRA;
            end
            fmt = FMT_R;
         end
         OP_LUI: begin
            num = INSN_LUI;
            fmt = FMT_U;
         end
         OP_BRANCH: begin
            num = BRANCH_NUM[f3];
            fmt = FMT_B;
         end
         OP_JALR: begin
            num = INSN_JALR;
            fmt = FMT_I;
         end
         OP_JAL: begin
            num = INSN_JAL;
            fmt = FMT_J;
         end
         OP_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               if (word == WORD_ECALL) begin
                  num = INSN_ECALL;
               end else if (word == WORD_EBREAK) begin
                  num = INSN_EBREAK;
               end
            end else begin
               num = SYS_NUM[f3];
            end
            fmt = FMT_I;
         end
         default: begin
            num = INSN_NONE;
         end
      endcase
   end

   always_comb begin
      result.number = num;
      result.fmt    = (num == INSN_NONE) ? FMT_UNKNOWN : fmt;
      result.opcode = op;
      result.funct3 = f3;
      result.funct7 = f7;
      result.rd     = word[11:7];
      result.rs1    = word[19:15];
      result.rs2    = word[24:20];
      result.imm    = '0;
      result.csr    = '0;
      if (num != INSN_NONE) begin
         unique case (fmt)
            FMT_I: begin
               if (op == OP_SYSTEM) begin
                  result.csr = word[31:20];
                  result.imm = {27'b0, word[19:15]};
               end else begin
                  result.imm = {{20{word[31]}}, word[31:20]};
               end
            end
            FMT_S: begin
               result.imm = {{20{word[31]}}, word[31:25], word[11:7]};
            end
            FMT_B: begin
               result.imm = {{19{word[31]}}, word[31], word[7], word[30:25],
                             word[11:8], 1'b0};
            end
            FMT_U: begin
               result.imm = {word[31:12], 12'b0};
            end
            FMT_J: begin
               result.imm = {{11{word[31]}}, word[31], word[19:12], word[20],
                             word[30:21], 1'b0};
            end
            default: begin
               result.imm = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/rv32i_instruction_decoder.sv]
// RV32I instruction decoder.
// The request channel (req_valid, req_stall, req_instruction_word) takes one
// 32-bit instruction word per transfer. The response channel (rsp_valid,
// rsp_stall, rsp_*) returns exactly one decoded result per accepted word, in
// order: the instruction number, format kind, raw bit fields, the
// sign-extended immediate and the CSR address for SYSTEM instructions.
// A word is captured in an input register, decoded by combinational logic
// and captured in the result register, from which the result is presented
// to the receiver and can be transferred when rsp_stall is low.
// With rsp_stall low the block accepts a word every cycle; the rate is one
// word per cycle, set by the two-stage register pipe.
// When the receiver stalls, the result register holds its contents and the
// input register still takes one more word; req_stall rises only when both
// registers are full and the result cannot move. Synchronous reset empties
// both stages; no result is presented until a new word is transferred.
`default_nettype none
`include "assert_macros.svh"

module rv32i_instruction_decoder
   import rvdec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_instruction_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [5:0]              rsp_instruction_number,
   output logic [2:0]              rsp_format_kind,
   output logic [6:0]              rsp_major_opcode,
   output logic [2:0]              rsp_minor_function,
   output logic [6:0]              rsp_upper_function,
   output logic [4:0]              rsp_dest_register,
   output logic [4:0]              rsp_source_register_a,
   output logic [4:0]              rsp_source_register_b,
   output logic signed [31:0]      rsp_immediate_value,
   output logic [11:0]             rsp_csr_address
);

   logic           word_valid_ff;
   logic           word_valid_in;
   logic [31:0]    word_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   dec_result_type rsp_ff;
   dec_result_type decoded;
   logic           rsp_load;
   logic           word_load;

   rvdec_decode u_decode (
      .word   (word_ff),
      .result (decoded)
   );

   assign rsp_load      = !rsp_valid_ff || !rsp_stall;
   assign word_load     = !word_valid_ff || rsp_load;
   assign req_stall     = !word_load;
   assign word_valid_in = word_load ? req_valid : word_valid_ff;
   assign rsp_valid_in  = rsp_load ? word_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_load && req_valid) begin
         word_ff <= req_instruction_word;
      end
      if (rsp_load && word_valid_ff) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_instruction_number = rsp_ff.number;
   assign rsp_format_kind        = rsp_ff.fmt;
   assign rsp_major_opcode       = rsp_ff.opcode;
   assign rsp_minor_function     = rsp_ff.funct3;
   assign rsp_upper_function     = rsp_ff.funct7;
   assign rsp_dest_register      = rsp_ff.rd;
   assign rsp_source_register_a  = rsp_ff.rs1;
   assign rsp_source_register_b  = rsp_ff.rs2;
   assign rsp_immediate_value    = rsp_ff.imm;
   assign rsp_csr_address        = rsp_ff.csr;

   `ASSERT_NEXT(a_req_fills_word, clock, reset, req_valid && !req_stall, word_valid_ff)
   `ASSERT_NEXT(a_word_moves_out, clock, reset, word_valid_ff && rsp_load, rsp_valid_ff)
   `ASSERT_IMPLY(a_unknown_clean, clock, reset,
      rsp_valid_ff && rsp_ff.number == INSN_NONE,
      rsp_ff.fmt == FMT_UNKNOWN && rsp_ff.imm == '0 && rsp_ff.csr == '0)
   `ASSERT_IMPLY(a_csr_only_system, clock, reset,
      rsp_valid_ff && rsp_ff.csr != '0, rsp_ff.opcode == OP_SYSTEM)

endmodule

`default_nettype wire

[test/rv32i_instruction_decoder_test.sv]
`timescale 1ns / 1ps

module rv32i_instruction_decoder_test
   import rvdec_pkg::*;
;

   localparam int RANDOM_PER_PHASE = 641;
   localparam int LONG_HOLD        = 60;
   localparam int DRAIN_CYCLES     = 8;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic [5:0]         number;
      logic [2:0]         fmt;
      logic [6:0]         opcode;
      logic [2:0]         funct3;
      logic [6:0]         funct7;
      logic [4:0]         rd;
      logic [4:0]         rs1;
      logic [4:0]         rs2;
      logic signed [31:0] imm;
      logic [11:0]        csr;
   } decoded_type;

   typedef struct packed {
      logic [31:0] word;
      logic        typed;
      decoded_type want;
   } directed_row_type;

   localparam logic [6:0] MAJOR_OPS [11] = '{OP_LOAD, OP_MISC_MEM, OP_IMM, OP_AUIPC,
                                             OP_STORE, OP_REG, OP_LUI, OP_BRANCH,
                                             OP_JALR, OP_JAL, OP_SYSTEM};

   localparam logic [5:0] LOAD_INSNS [8] = '{INSN_LB, INSN_LH, INSN_LW, INSN_NONE,
                                             INSN_LBU, INSN_LHU, INSN_NONE, INSN_NONE};
   localparam logic [5:0] FENCE_INSNS [8] = '{INSN_FENCE, INSN_FENCE_I, INSN_NONE, INSN_NONE,
                                              INSN_NONE, INSN_NONE, INSN_NONE, INSN_NONE};
   localparam logic [5:0] ALU_IMM_INSNS [8] = '{INSN_ADDI, INSN_SLLI, INSN_SLTI, INSN_SLTIU,
                                                INSN_XORI, INSN_SRLI, INSN_ORI, INSN_ANDI};
   localparam logic [5:0] STORE_INSNS [8] = '{INSN_SB, INSN_SH, INSN_SW, INSN_NONE,
                                              INSN_NONE, INSN_NONE, INSN_NONE, INSN_NONE};
   localparam logic [5:0] ALU_REG_INSNS [8] = '{INSN_ADD, INSN_SLL, INSN_SLT, INSN_SLTU,
                                                INSN_XOR, INSN_SRL, INSN_OR, INSN_AND};
   localparam logic [5:0] BRANCH_INSNS [8] = '{INSN_BEQ, INSN_BNE, INSN_NONE, INSN_NONE,
                                               INSN_BLT, INSN_BGE, INSN_BLTU, INSN_BGEU};
   localparam logic [5:0] CSR_INSNS [8] = '{INSN_NONE, INSN_CSRRW, INSN_CSRRS, INSN_CSRRC,
                                            INSN_NONE, INSN_CSRRWI, INSN_CSRRSI, INSN_CSRRCI};

   localparam decoded_type NO_CHECK = '0;

   localparam directed_row_type DIRECTED_WORDS [26] = '{
      '{32'h0000_0000, 1'b1, '{INSN_NONE, FMT_UNKNOWN, 7'h00, 3'd0, 7'h00,
                               5'd0, 5'd0, 5'd0, 32'h0000_0000, 12'h000}},
      '{32'hFFFF_FFFF, 1'b1, '{INSN_NONE, FMT_UNKNOWN, 7'h7F, 3'd7, 7'h7F,
                               5'd31, 5'd31, 5'd31, 32'h0000_0000, 12'h000}},
      '{WORD_ECALL, 1'b1, '{INSN_ECALL, FMT_I, OP_SYSTEM, 3'd0, 7'h00,
                            5'd0, 5'd0, 5'd0, 32'h0000_0000, 12'h000}},
      '{WORD_EBREAK, 1'b1, '{INSN_EBREAK, FMT_I, OP_SYSTEM, 3'd0, 7'h00,
                             5'd0, 5'd0, 5'd1, 32'h0000_0000, 12'h001}},
      '{32'h0020_0073, 1'b1, '{INSN_NONE, FMT_UNKNOWN, OP_SYSTEM, 3'd0, 7'h00,
                               5'd0, 5'd0, 5'd2, 32'h0000_0000, 12'h000}},
      '{32'hFFF0_0013, 1'b1, '{INSN_ADDI, FMT_I, OP_IMM, 3'd0, 7'h7F,
                               5'd0, 5'd0, 5'd31, 32'hFFFF_FFFF, 12'h000}},
      '{32'hFFFF_F037, 1'b1, '{INSN_LUI, FMT_U, OP_LUI, 3'd7, 7'h7F,
                               5'd0, 5'd31, 5'd31, 32'hFFFF_F000, 12'h000}},
      '{32'h8000_0063, 1'b0, NO_CHECK},
      '{32'h7FF0_0003, 1'b0, NO_CHECK},
      '{32'h0000_3003, 1'b0, NO_CHECK},
      '{32'h0000_200F, 1'b0, NO_CHECK},
      '{32'h0000_000F, 1'b0, NO_CHECK},
      '{32'h0000_100F, 1'b0, NO_CHECK},
      '{32'h4000_5013, 1'b0, NO_CHECK},
      '{32'h0200_5013, 1'b0, NO_CHECK},
      '{32'hFE00_1013, 1'b0, NO_CHECK},
      '{32'h4000_0033, 1'b0, NO_CHECK},
      '{32'h0200_5033, 1'b0, NO_CHECK},
      '{32'hFE00_7033, 1'b0, NO_CHECK},
      '{32'hFE00_2FA3, 1'b0, NO_CHECK},
      '{32'h0000_2063, 1'b0, NO_CHECK},
      '{32'hFFFF_F06F, 1'b0, NO_CHECK},
      '{32'h8000_0017, 1'b0, NO_CHECK},
      '{32'hFFF0_8067, 1'b0, NO_CHECK},
      '{32'hFFFF_F0F3, 1'b0, NO_CHECK},
      '{32'h3400_1073, 1'b0, NO_CHECK}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [31:0]       req_instruction_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [5:0]        rsp_instruction_number;
   logic [2:0]        rsp_format_kind;
   logic [6:0]        rsp_major_opcode;
   logic [2:0]        rsp_minor_function;
   logic [6:0]        rsp_upper_function;
   logic [4:0]        rsp_dest_register;
   logic [4:0]        rsp_source_register_a;
   logic [4:0]        rsp_source_register_b;
   logic signed [31:0] rsp_immediate_value;
   logic [11:0]       rsp_csr_address;

   decoded_type pending_decodes [$];
   logic [31:0] pending_words [$];
   int          mismatch_count = 0;
   int          error_count = 0;
   int          idle_pct = 12;
   int          stall_pct = 55;
   bit          hold_request = 1'b0;
   int          hold_count = 0;

   rv32i_instruction_decoder u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_instruction_word  (req_instruction_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_instruction_number(rsp_instruction_number),
      .rsp_format_kind       (rsp_format_kind),
      .rsp_major_opcode      (rsp_major_opcode),
      .rsp_minor_function    (rsp_minor_function),
      .rsp_upper_function    (rsp_upper_function),
      .rsp_dest_register     (rsp_dest_register),
      .rsp_source_register_a (rsp_source_register_a),
      .rsp_source_register_b (rsp_source_register_b),
      .rsp_immediate_value   (rsp_immediate_value),
      .rsp_csr_address       (rsp_csr_address)
   );

   function automatic decoded_type decode_rv32i(input logic [31:0] w);
      decoded_type d;
      d = '0;
      d.opcode = w[6:0];
      d.funct3 = w[14:12];
      d.funct7 = w[31:25];
      d.rd     = w[11:7];
      d.rs1    = w[19:15];
      d.rs2    = w[24:20];
      d.number = INSN_NONE;
      d.fmt    = FMT_UNKNOWN;
      case (d.opcode)
         OP_LOAD: begin
            d.number = LOAD_INSNS[d.funct3];
            d.fmt = FMT_I;
         end
         OP_MISC_MEM: begin
            d.number = FENCE_INSNS[d.funct3];
            d.fmt = FMT_I;
         end
         OP_IMM: begin
            d.number = ALU_IMM_INSNS[d.funct3];
            if (d.funct3 == F3_SHIFT_RIGHT && d.funct7 != 7'h00) d.number = INSN_SRAI;
            d.fmt = FMT_I;
         end
         OP_AUIPC: begin
            d.number = INSN_AUIPC;
            d.fmt = FMT_U;
         end
         OP_STORE: begin
            d.number = STORE_INSNS[d.funct3];
            d.fmt = FMT_S;
         end
         OP_REG: begin
            d.number = ALU_REG_INSNS[d.funct3];
            if (d.funct7 != 7'h00) begin
               if (d.funct3 == F3_ADD_SUB) d.number = INSN_SUB;
               if (d.funct3 == F3_SHIFT_RIGHT) d.number = INSN_SRA;
            end
            d.fmt = FMT_R;
         end
         OP_LUI: begin
            d.number = INSN_LUI;
            d.fmt = FMT_U;
         end
         OP_BRANCH: begin
            d.number = BRANCH_INSNS[d.funct3];
            d.fmt = FMT_B;
         end
         OP_JALR: begin
            d.number = INSN_JALR;
            d.fmt = FMT_I;
         end
         OP_JAL: begin
            d.number = INSN_JAL;
            d.fmt = FMT_J;
         end
         OP_SYSTEM: begin
            if (d.funct3 == F3_PRIV)
               d.number = (w == WORD_ECALL) ? INSN_ECALL :
                          (w == WORD_EBREAK) ? INSN_EBREAK : INSN_NONE;
            else
               d.number = CSR_INSNS[d.funct3];
            d.fmt = FMT_I;
         end
         default: ;
      endcase
      if (d.number == INSN_NONE) begin
         d.fmt = FMT_UNKNOWN;
      end else begin
         case (d.fmt)
            FMT_I: begin
               if (d.opcode == OP_SYSTEM) begin
                  d.csr = w[31:20];
                  d.imm = {27'd0, d.rs1};
               end else begin
                  d.imm = {{20{w[31]}}, w[31:20]};
               end
            end
            FMT_S: d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B: d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U: d.imm = {w[31:12], 12'd0};
            FMT_J: d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: ;
         endcase
      end
      return d;
   endfunction

   // Mostly well-formed words on a known major opcode with random content,
   // some exact privileged words, and some raw noise.
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      int pick;
      pick = $urandom_range(99);
      w = $urandom;
      if (pick < 12) begin
         return w;
      end else if (pick < 16) begin
         return $urandom_range(1) ? WORD_EBREAK : WORD_ECALL;
      end
      w[6:0] = MAJOR_OPS[$urandom_range(10)];
      if ($urandom_range(1)) w[31:25] = 7'h00;
      return w;
   endfunction

   task automatic issue_word(input logic [31:0] w, input decoded_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= w;
      do @(posedge clock); while (req_stall);
      pending_decodes.push_back(want);
      pending_words.push_back(w);
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && hold_count < LONG_HOLD) begin
            rsp_stall <= 1'b1;
            hold_count++;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      logic [31:0] w;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_instruction_number, rsp_format_kind, rsp_major_opcode,
                 rsp_minor_function, rsp_upper_function, rsp_dest_register,
                 rsp_source_register_a, rsp_source_register_b, rsp_immediate_value,
                 rsp_csr_address};
         if (pending_decodes.size() == 0) begin
            error_count++;
            $display("Unexpected result transfer at %0t.", $realtime);
         end else begin
            want = pending_decodes.pop_front();
            w = pending_words.pop_front();
            if (got.number !== want.number || got.fmt !== want.fmt ||
                got.opcode !== want.opcode || got.funct3 !== want.funct3 ||
                got.funct7 !== want.funct7 || got.rd !== want.rd ||
                got.rs1 !== want.rs1 || got.rs2 !== want.rs2 ||
                got.imm !== want.imm || got.csr !== want.csr) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Mismatch for word %h:", w);
                  $display("  expected insn %0d fmt %0d op %h f3 %0d f7 %h rd %0d rs1 %0d",
                           want.number, want.fmt, want.opcode, want.funct3, want.funct7,
                           want.rd, want.rs1);
                  $display("           rs2 %0d imm %h csr %h", want.rs2, want.imm, want.csr);
                  $display("  actual   insn %0d fmt %0d op %h f3 %0d f7 %h rd %0d rs1 %0d",
                           got.number, got.fmt, got.opcode, got.funct3, got.funct7,
                           got.rd, got.rs1);
                  $display("           rs2 %0d imm %h csr %h", got.rs2, got.imm, got.csr);
               end
            end
         end
      end
   end

   initial begin
      logic [31:0] w;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_WORDS[i]) begin
         w = DIRECTED_WORDS[i].word;
         issue_word(w, DIRECTED_WORDS[i].typed ? DIRECTED_WORDS[i].want : decode_rv32i(w));
      end

      repeat (RANDOM_PER_PHASE) begin
         w = random_instruction();
         issue_word(w, decode_rv32i(w));
      end

      idle_pct = 55;
      stall_pct = 12;
      repeat (RANDOM_PER_PHASE) begin
         w = random_instruction();
         issue_word(w, decode_rv32i(w));
      end

      // The receiver holds off for a long stretch while words keep coming,
      // so both stages fill and the input side must stall.
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b1;
      repeat (RANDOM_PER_PHASE) begin
         w = random_instruction();
         issue_word(w, decode_rv32i(w));
      end
      req_valid <= 1'b0;

      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += mismatch_count + pending_decodes.size();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rvdec_pkg.sv
rtl/core/rvdec_decode.sv
rtl/core/rv32i_instruction_decoder.sv
test/rv32i_instruction_decoder_test.sv
